// ===== src/e2e_profile7_checker_assert.svh =====
// assertion macros for the profile 7 receive checker
`ifndef E2E_PROFILE7_CHECKER_ASSERT_SVH
`define E2E_PROFILE7_CHECKER_ASSERT_SVH

// overlapping implication, checked on every clock outside reset
`define E2E7_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// non-overlapping implication, consequent checked in the cycle after the antecedent
`define E2E7_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/e2e7_pkg.sv =====
// shared types, codes and helpers for the profile 7 receive checker
package e2e7_pkg;

    localparam int LEN_W      = 23;
    localparam int OFFSET_W   = 22;
    localparam int ADDR_W     = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [LEN_W-1:0] MAX_MSG_BYTES = 23'd4194304;
    localparam logic [LEN_W-1:0] HDR_BYTES     = 23'd20;

    // header layout, positions relative to the header offset
    localparam logic [4:0] HDR_CRC_END = 5'd8;
    localparam logic [4:0] HDR_LEN_END = 5'd12;
    localparam logic [4:0] HDR_CNT_END = 5'd16;

    localparam logic [63:0] CRC_POLY = 64'hC96C5795D7870F42;
    localparam logic [63:0] ONES_64  = 64'hFFFFFFFFFFFFFFFF;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_NO_DATA = 1'b1;

    localparam logic RC_OK          = 1'b0;
    localparam logic RC_WRONG_INPUT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SOME_LOST = 3'd1;
    localparam logic [2:0] ST_ERROR     = 3'd2;
    localparam logic [2:0] ST_REPEATED  = 3'd3;
    localparam logic [2:0] ST_NO_DATA   = 3'd4;
    localparam logic [2:0] ST_WRONG_SEQ = 3'd5;

    localparam logic [2:0] REG_HEADER_OFFSET     = 3'd0;
    localparam logic [2:0] REG_EXPECTED_DATA_ID  = 3'd1;
    localparam logic [2:0] REG_MAX_COUNTER_DELTA = 3'd2;
    localparam logic [2:0] REG_MIN_LENGTH        = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH        = 3'd4;

    typedef struct packed {
        logic [OFFSET_W-1:0] header_offset;
        logic [31:0]         expected_data_id;
        logic [30:0]         max_counter_delta;
        logic [LEN_W-1:0]    min_length;
        logic [LEN_W-1:0]    max_length;
    } t_cfg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        return_code;
        logic [2:0]  status;
        logic [31:0] received_counter;
    } t_result;

    typedef struct packed {
        logic [63:0]      crc_accum;
        logic [LEN_W-1:0] byte_count;
        logic [31:0]      rx_length;
        logic [31:0]      rx_counter;
        logic [31:0]      rx_data_id;
        logic [63:0]      rx_crc;
        logic [31:0]      last_counter;
        logic [2:0]       last_status;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        crc_accum:    ONES_64,
        byte_count:   '0,
        rx_length:    '0,
        rx_counter:   '0,
        rx_data_id:   '0,
        rx_crc:       '0,
        last_counter: 32'hFFFFFFFF,
        last_status:  ST_ERROR
    };

    // per-message fields back to reset, sequence history kept
    function automatic t_ctx clear_msg(input t_ctx ctx);
        t_ctx c;
        c              = CTX_RESET;
        c.last_counter = ctx.last_counter;
        c.last_status  = ctx.last_status;
        return c;
    endfunction

    // reflected crc-64 ecma-182, one byte
    function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/e2e7_if.sv =====
// valid/ready channel interfaces for message bytes and check results
interface e2e7_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

interface e2e7_out_if;
    logic        valid;
    logic        ready;
    logic        return_code;
    logic [2:0]  status;
    logic [31:0] received_counter;

    modport source (output valid, return_code, status, received_counter, input ready);
    modport sink   (input valid, return_code, status, received_counter, output ready);
endinterface

// ===== src/e2e_profile7_checker.sv =====
// end-to-end profile 7 receive checker, top level
// results pass the item register and the result queue on the way to the output
// throughput: one byte per cycle while ready, set by the read-modify-write of the
//   message context entry, with the write-back forwarded to the following read
// input ready drops only while the four-entry result queue could overflow
// reset (synchronous, active low) loads register defaults and makes the context
//   entry read as its reset value until first written; no clearing pass
module e2e_profile7_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    e2e7_in_if.sink                     i_in,
    e2e7_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [e2e7_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import e2e7_pkg::*;

    t_cfg             cfg;
    t_item            r_s1_item;
    logic             r_s1_valid;
    logic             in_xfer;
    t_ctx             ctx_rd;
    t_ctx             ctx_wr;
    logic             res_valid;
    t_result          res;
    t_result          out_data;
    logic             out_valid;
    logic [FIFO_AW:0] fifo_cnt;

    e2e7_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // room for the queued results plus the one in flight
    assign i_in.ready = (({1'b0, fifo_cnt} + (FIFO_AW + 2)'(r_s1_valid))
                         < (FIFO_AW + 2)'(FIFO_DEPTH));
    assign in_xfer = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.command   <= i_in.command;
            r_s1_item.data_byte <= i_in.data_byte;
            r_s1_item.last_byte <= i_in.last_byte;
        end
    end

    e2e7_ctx_mem u_ctx_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_wr_en   (r_s1_valid),
        .i_wr_data (ctx_wr),
        .o_rd_data (ctx_rd)
    );

    e2e7_update u_update (
        .i_cfg       (cfg),
        .i_ctx       (ctx_rd),
        .i_item      (r_s1_item),
        .o_ctx       (ctx_wr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    e2e7_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid && res_valid),
        .i_data  (res),
        .i_pop   (out_valid && o_out.ready),
        .o_valid (out_valid),
        .o_data  (out_data),
        .o_cnt   (fifo_cnt)
    );

    assign o_out.valid            = out_valid;
    assign o_out.return_code      = out_data.return_code;
    assign o_out.status           = out_data.status;
    assign o_out.received_counter = out_data.received_counter;

endmodule

// ===== src/e2e7_regs.sv =====
// apb configuration registers
module e2e7_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [e2e7_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output e2e7_pkg::t_cfg              o_cfg
);
    import e2e7_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_offset     <= '0;
            r_cfg.expected_data_id  <= '0;
            r_cfg.max_counter_delta <= 31'd1;
            r_cfg.min_length        <= HDR_BYTES;
            r_cfg.max_length        <= MAX_MSG_BYTES;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER_OFFSET:     r_cfg.header_offset     <= pwdata[OFFSET_W-1:0];
                REG_EXPECTED_DATA_ID:  r_cfg.expected_data_id  <= pwdata;
                REG_MAX_COUNTER_DELTA: r_cfg.max_counter_delta <= pwdata[30:0];
                REG_MIN_LENGTH:        r_cfg.min_length        <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH:        r_cfg.max_length        <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER_OFFSET:     prdata = 32'(r_cfg.header_offset);
            REG_EXPECTED_DATA_ID:  prdata = r_cfg.expected_data_id;
            REG_MAX_COUNTER_DELTA: prdata = 32'(r_cfg.max_counter_delta);
            REG_MIN_LENGTH:        prdata = 32'(r_cfg.min_length);
            REG_MAX_LENGTH:        prdata = 32'(r_cfg.max_length);
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== src/e2e7_ctx_mem.sv =====
// message context memory, registered read, write-back forwarding
module e2e7_ctx_mem (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic           i_wr_en,
    input  e2e7_pkg::t_ctx i_wr_data,
    output e2e7_pkg::t_ctx o_rd_data
);
    import e2e7_pkg::*;

    t_ctx r_mem [1];
    t_ctx r_rd_data;
    t_ctx r_fwd_data;
    logic r_fwd_valid;
    logic r_rd_valid;
    logic r_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[0] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[0];
        end
        r_fwd_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_init;
            end
            // write-back of the previous item lands on the edge of this read
            r_fwd_valid <= i_wr_en && i_rd_en;
        end
    end

    assign o_rd_data = r_fwd_valid ? r_fwd_data :
                       (r_rd_valid ? r_rd_data : CTX_RESET);

endmodule

// ===== src/e2e7_update.sv =====
// per-byte context update and end-of-message verdict
module e2e7_update (
    input  e2e7_pkg::t_cfg    i_cfg,
    input  e2e7_pkg::t_ctx    i_ctx,
    input  e2e7_pkg::t_item   i_item,
    output e2e7_pkg::t_ctx    o_ctx,
    output logic              o_res_valid,
    output e2e7_pkg::t_result o_res
);
    import e2e7_pkg::*;

    t_ctx             ctx_take;
    logic [LEN_W:0]   pos_diff;
    logic             in_hdr;
    logic [4:0]       rel;
    logic             overflow;
    logic [LEN_W-1:0] hdr_end;
    logic             wrong_input;
    logic             bad_msg;
    logic [31:0]      delta;
    logic [2:0]       seq_st;

    always_comb begin
        pos_diff = {1'b0, i_ctx.byte_count} - {2'b00, i_cfg.header_offset};
        in_hdr   = !pos_diff[LEN_W] && (pos_diff[LEN_W-1:0] < HDR_BYTES);
        rel      = pos_diff[4:0];
        overflow = (i_ctx.byte_count >= MAX_MSG_BYTES);

        ctx_take = i_ctx;
        if (!overflow) begin
            ctx_take.byte_count = i_ctx.byte_count + LEN_W'(1);
            if (in_hdr && (rel < HDR_CRC_END)) begin
                // crc field is captured but not covered
                ctx_take.rx_crc = {i_ctx.rx_crc[55:0], i_item.data_byte};
            end else begin
                ctx_take.crc_accum = crc64_byte(i_ctx.crc_accum, i_item.data_byte);
                if (in_hdr) begin
                    if (rel < HDR_LEN_END) begin
                        ctx_take.rx_length = {i_ctx.rx_length[23:0], i_item.data_byte};
                    end else if (rel < HDR_CNT_END) begin
                        ctx_take.rx_counter = {i_ctx.rx_counter[23:0], i_item.data_byte};
                    end else begin
                        ctx_take.rx_data_id = {i_ctx.rx_data_id[23:0], i_item.data_byte};
                    end
                end
            end
        end
    end

    always_comb begin
        hdr_end     = {1'b0, i_cfg.header_offset} + HDR_BYTES;
        wrong_input = overflow ||
                      (ctx_take.byte_count < i_cfg.min_length) ||
                      (ctx_take.byte_count > i_cfg.max_length) ||
                      (ctx_take.byte_count < hdr_end);
        bad_msg     = ((ctx_take.crc_accum ^ ONES_64) != ctx_take.rx_crc) ||
                      (ctx_take.rx_data_id != i_cfg.expected_data_id) ||
                      (ctx_take.rx_length != 32'(ctx_take.byte_count));
        delta       = ctx_take.rx_counter - i_ctx.last_counter;
        if (delta > {1'b0, i_cfg.max_counter_delta}) begin
            seq_st = ST_WRONG_SEQ;
        end else if (delta == 32'd0) begin
            seq_st = ST_REPEATED;
        end else if (delta == 32'd1) begin
            seq_st = ST_OK;
        end else begin
            seq_st = ST_SOME_LOST;
        end
    end

    always_comb begin
        o_ctx       = ctx_take;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.command == CMD_NO_DATA) begin
            o_ctx             = clear_msg(i_ctx);
            o_ctx.last_status = ST_NO_DATA;
            o_res_valid       = 1'b1;
            o_res.return_code = RC_OK;
            o_res.status      = ST_NO_DATA;
        end else if (i_item.last_byte) begin
            o_ctx       = clear_msg(ctx_take);
            o_res_valid = 1'b1;
            if (wrong_input) begin
                o_res.return_code = RC_WRONG_INPUT;
                o_res.status      = i_ctx.last_status;
            end else if (bad_msg) begin
                o_res.return_code      = RC_OK;
                o_res.status           = ST_ERROR;
                o_res.received_counter = ctx_take.rx_counter;
                o_ctx.last_status      = ST_ERROR;
            end else begin
                o_res.return_code      = RC_OK;
                o_res.status           = seq_st;
                o_res.received_counter = ctx_take.rx_counter;
                o_ctx.last_status      = seq_st;
                o_ctx.last_counter     = ctx_take.rx_counter;
            end
        end
    end

endmodule

// ===== src/e2e7_out_fifo.sv =====
// result queue between the update stage and the output channel
module e2e7_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  e2e7_pkg::t_result           i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output e2e7_pkg::t_result           o_data,
    output logic [e2e7_pkg::FIFO_AW:0]  o_cnt
);
    import e2e7_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_cnt   = r_cnt;

endmodule

// ===== src/e2e7_checker.sv =====
// port-level assertions for the profile 7 receive checker, bound to the top level
`include "e2e_profile7_checker_assert.svh"

module e2e7_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_return_code,
    input logic [2:0]  i_status,
    input logic [31:0] i_received_counter
);
    import e2e7_pkg::*;

    `E2E7_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_return_code) && $stable(i_status) && $stable(i_received_counter), "result changed while stalled")
    `E2E7_ASSERT_NOW(a_wrong_input_counter, i_out_valid && (i_return_code == RC_WRONG_INPUT), i_received_counter == 32'd0, "wrong input result carries a counter")
    `E2E7_ASSERT_NOW(a_no_data_result, i_out_valid && (i_status == ST_NO_DATA) && (i_return_code == RC_OK), i_received_counter == 32'd0, "no-new-data result carries a counter")
    `E2E7_ASSERT_NOW(a_ready_after_reset, $rose(i_rst_n), i_in_ready, "input not ready after reset")

endmodule

bind e2e_profile7_checker e2e7_checker u_e2e7_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_return_code      (o_out.return_code),
    .i_status           (o_out.status),
    .i_received_counter (o_out.received_counter)
);
